FILE: src/kmp_pkg.sv
// ----------------------------------------------------------------------------
// kmp_pkg
// Shared types for the KMP string matcher: the input and result beats.
// ----------------------------------------------------------------------------
package kmp_pkg;

    localparam int SYMBOL_W = 8;
    localparam int START_W  = 16;

    // Item modes.
    localparam logic MODE_PATTERN = 1'b0;
    localparam logic MODE_TEXT    = 1'b1;

    typedef struct packed {
        logic                mode;
        logic [SYMBOL_W-1:0] symbol;
        logic                last;
    } item_t;

    typedef struct packed {
        logic               match_valid;
        logic [START_W-1:0] match_start;
        logic               text_end;
        logic               pattern_overflow;
    } result_t;

endpackage

FILE: src/kmp_string_matcher.sv
// ----------------------------------------------------------------------------
// kmp_string_matcher
// Knuth-Morris-Pratt matcher built around a pattern memory and a failure-link
// memory, both synchronous with a registered read port.
// ----------------------------------------------------------------------------
// Usage: send pattern bytes (mode 0) first, ending with last set, then text
// bytes (mode 1). A mode 0 beat that arrives while no pattern is loading
// starts a new pattern. Bytes beyond PATTERN_MAX are dropped, and every text
// result of that pattern then carries pattern_overflow.
// The item channel takes one beat, then stalls while the block walks the
// failure links: the walk over the shared memory read port fetches one link
// per step. Over a text run the links followed never exceed the bytes
// scanned. Bytes past the pattern bound are dropped without a walk.
// A result beat is registered as the walk ends, only for a text byte
// that ends a match (overlapping matches included) or carries last.
// The result sits in an output register; while result_stall is high the
// block can still take and work on the next item, and waits only when a
// second result is ready before the first has left.
// Reset clears the pattern, the match state and the output; the memories
// are not cleared and are read only where written.
// ----------------------------------------------------------------------------
module kmp_string_matcher #(
    parameter int PATTERN_MAX   = 64,
    parameter int POSITION_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  kmp_pkg::item_t   item,
    input  logic            item_valid,
    output logic            item_stall,
    output kmp_pkg::result_t result,
    output logic            result_valid,
    input  logic            result_stall
);
    import kmp_pkg::*;

    localparam int AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam int PW = POSITION_BITS;
    localparam logic [LW-1:0] PAT_MAX_L = LW'(PATTERN_MAX);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    // Pattern bytes and plus-one coded failure links.
    logic [SYMBOL_W-1:0] pat_mem  [PATTERN_MAX];
    logic [LW-1:0]       fail_mem [PATTERN_MAX+1];

    logic                state_reg, state_next;
    logic [LW-1:0]       k_reg, k_next;
    logic                mode_reg, mode_next;
    logic [SYMBOL_W-1:0] sym_reg, sym_next;
    logic                last_reg, last_next;
    logic [LW-1:0]       len_reg, len_next;
    logic [LW-1:0]       build_reg, build_next;
    logic [LW-1:0]       match_reg, match_next;
    logic [PW-1:0]       pos_reg, pos_next;
    logic                overflow_reg, overflow_next;
    logic                loading_reg, loading_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg, out_next;

    logic [SYMBOL_W-1:0] pat_rd_reg;
    logic [LW-1:0]       fail_rd_reg;
    logic                fail_zero_reg;

    logic                pat_we;
    logic [AW-1:0]       pat_waddr;
    logic                fail_we;
    logic [LW-1:0]       fail_waddr;
    logic [LW-1:0]       fail_wdata;
    logic                rd_en;
    logic [LW-1:0]       rd_addr;

    logic [LW-1:0]       eff_len;
    logic [LW-1:0]       eff_build;
    logic [LW-1:0]       fail_val;
    logic                step_done;
    logic                hit;
    logic                out_free;
    logic [PW+15:0]      pos_ext;
    logic [LW+15:0]      len_ext;
    logic [START_W-1:0]  start_val;

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign out_free  = !out_valid_reg || !result_stall;
    assign fail_val  = fail_zero_reg ? '0 : fail_rd_reg;
    assign step_done = (k_reg == '0) || (sym_reg == pat_rd_reg);
    assign hit       = (len_reg != '0) && (k_reg == len_reg);
    assign eff_len   = loading_reg ? len_reg : '0;
    assign eff_build = loading_reg ? build_reg : '0;

    // Only the low 16 bits of the start offset are reported, so the
    // subtraction is done modulo 2^16.
    assign pos_ext   = {16'b0, pos_reg};
    assign len_ext   = {16'b0, len_reg};
    assign start_val = pos_ext[15:0] + 16'd1 - len_ext[15:0];

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        mode_next      = mode_reg;
        sym_next       = sym_reg;
        last_next      = last_reg;
        len_next       = len_reg;
        build_next     = build_reg;
        match_next     = match_reg;
        pos_next       = pos_reg;
        overflow_next  = overflow_reg;
        loading_next   = loading_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_next       = out_reg;
        pat_we         = 1'b0;
        pat_waddr      = eff_len[AW-1:0];
        fail_we        = 1'b0;
        fail_waddr     = len_reg + LW'(1);
        fail_wdata     = k_reg + LW'(1);
        rd_en          = 1'b0;
        rd_addr        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    mode_next = item.mode;
                    sym_next  = item.symbol;
                    last_next = item.last;
                    if (item.mode == MODE_PATTERN)
                    begin
                        len_next      = eff_len;
                        build_next    = eff_build;
                        match_next    = '0;
                        pos_next      = '0;
                        loading_next  = !item.last;
                        overflow_next = loading_reg && overflow_reg;
                        if (eff_len >= PAT_MAX_L)
                        begin
                            overflow_next = 1'b1;
                        end
                        else
                        begin
                            pat_we     = 1'b1;
                            k_next     = eff_build;
                            state_next = ST_SCAN;
                            if (eff_build != '0)
                            begin
                                rd_en   = 1'b1;
                                rd_addr = eff_build - LW'(1);
                            end
                        end
                    end
                    else
                    begin
                        loading_next = 1'b0;
                        state_next   = ST_SCAN;
                        if (len_reg != '0)
                        begin
                            k_next  = match_reg + LW'(1);
                            rd_en   = 1'b1;
                            rd_addr = match_reg;
                        end
                        else
                        begin
                            k_next = '0;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (!step_done)
                begin
                    // Mismatch: follow the failure link and fetch the next entry.
                    k_next = fail_val;
                    if (fail_val != '0)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = fail_val - LW'(1);
                    end
                end
                else if (mode_reg == MODE_PATTERN)
                begin
                    fail_we    = 1'b1;
                    build_next = k_reg + LW'(1);
                    len_next   = len_reg + LW'(1);
                    state_next = ST_IDLE;
                end
                else if (!((hit || last_reg) && !out_free))
                begin
                    // The link of the full pattern equals the last build index.
                    if (len_reg != '0)
                    begin
                        match_next = hit ? (build_reg - LW'(1)) : k_reg;
                    end
                    if (pos_reg != '1)
                    begin
                        pos_next = pos_reg + PW'(1);
                    end
                    if (last_reg)
                    begin
                        match_next = '0;
                        pos_next   = '0;
                    end
                    if (hit || last_reg)
                    begin
                        out_valid_next            = 1'b1;
                        out_next.match_valid      = hit;
                        out_next.match_start      = hit ? start_val : '0;
                        out_next.text_end         = last_reg;
                        out_next.pattern_overflow = overflow_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            len_reg       <= '0;
            build_reg     <= '0;
            match_reg     <= '0;
            pos_reg       <= '0;
            overflow_reg  <= 1'b0;
            loading_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            len_reg       <= len_next;
            build_reg     <= build_next;
            match_reg     <= match_next;
            pos_reg       <= pos_next;
            overflow_reg  <= overflow_next;
            loading_reg   <= loading_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        sym_reg  <= sym_next;
        last_reg <= last_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (pat_we)
        begin
            pat_mem[pat_waddr] <= sym_next;
        end
        if (rd_en)
        begin
            pat_rd_reg <= pat_mem[rd_addr[AW-1:0]];
        end
    end

    // Entry zero of the failure table is never stored; it always reads as zero.
    always_ff @(posedge clk)
    begin
        if (fail_we)
        begin
            fail_mem[fail_waddr] <= fail_wdata;
        end
        if (rd_en)
        begin
            fail_rd_reg   <= fail_mem[rd_addr];
            fail_zero_reg <= (rd_addr == '0);
        end
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// KMP string matcher testbench
// Drives pattern and text beats through the item channel with random gaps and
// output back-pressure, predicts match and text-end reports with an in-bench
// KMP model or pinned rows, and compares each beat field by field in order.
// Covers empty pattern, overlapping matches, text arriving while a pattern
// loads, pattern overflow and a long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

    import kmp_pkg::*;

    localparam int          PAT_MAX      = 64;
    localparam int          POS_BITS     = 16;
    localparam int unsigned POS_MAX      = (1 << POS_BITS) - 1;
    localparam int          IDLE_PCT     = 21;
    localparam int          HOLD_CYCLES  = 200;
    localparam int          DRAIN_CYCLES = 200;
    localparam int          RANDOM_BEATS = 650;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_SILENT,
        CHK_REPORT
    } row_chk_t;

    typedef struct {
        item_t    it;
        row_chk_t chk;
        result_t  pin;
    } dir_row_t;

    logic    clk;
    logic    rst_n        = 1'b0;
    item_t   item         = '0;
    logic    item_valid   = 1'b0;
    logic    item_stall;
    result_t result;
    logic    result_valid;
    logic    result_stall = 1'b0;

    bit hold_go  = 1'b0;
    bit hold_off = 1'b0;
    bit calm     = 1'b0;

    // Prediction state.
    logic [7:0]  pat_mem  [PAT_MAX];
    logic [6:0]  link_mem [PAT_MAX + 1];
    int unsigned pat_len;
    int unsigned border_len;   // plus-one coded, zero stands for the -1 link
    int unsigned scan_len;
    int unsigned scan_pos;
    bit          pat_ovf;
    bit          pat_open;

    result_t  pending_reports [$];
    dir_row_t dir_tab [$];
    result_t  want;

    int errors       = 0;
    int beats_in     = 0;
    int reports_seen = 0;
    int hits_seen    = 0;
    int ovf_seen     = 0;

    kmp_string_matcher #(
        .PATTERN_MAX   (PAT_MAX),
        .POSITION_BITS (POS_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #(10_000_000);
        $display("Timed out with %0d reports still outstanding.", pending_reports.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // KMP over one beat: returns 1 when the beat produces a report.
    function automatic bit kmp_step(input item_t it, output result_t res);
        int unsigned k;
        int unsigned hit_at;
        bit          hit;
        hit    = 1'b0;
        hit_at = 0;
        res    = '0;
        if (it.mode == MODE_PATTERN)
        begin
            if (!pat_open)
            begin
                pat_len     = 0;
                border_len  = 0;
                link_mem[0] = '0;
                pat_ovf     = 1'b0;
                scan_len    = 0;
                scan_pos    = 0;
                pat_open    = 1'b1;
            end
            if (pat_len >= PAT_MAX)
            begin
                pat_ovf = 1'b1;
            end
            else
            begin
                pat_mem[pat_len] = it.symbol;
                k = border_len;
                while (k > 0 && it.symbol != pat_mem[k - 1])
                    k = link_mem[k - 1];
                link_mem[pat_len + 1] = 7'(k + 1);
                border_len = k + 1;
                pat_len++;
            end
            if (it.last)
                pat_open = 1'b0;
            return 1'b0;
        end

        pat_open = 1'b0;
        if (pat_len > 0)
        begin
            k = scan_len + 1;
            while (k > 0 && it.symbol != pat_mem[k - 1])
                k = link_mem[k - 1];
            if (k == pat_len)
            begin
                hit    = 1'b1;
                hit_at = scan_pos + 1 - pat_len;
                // Continue from the border of the full pattern so overlaps count.
                k = link_mem[pat_len] - 1;
            end
            scan_len = k;
        end
        if (scan_pos < POS_MAX)
            scan_pos++;
        if (it.last)
        begin
            scan_len = 0;
            scan_pos = 0;
        end
        if (!hit && !it.last)
            return 1'b0;
        res.match_valid      = hit;
        res.match_start      = 16'(hit_at);
        res.text_end         = it.last;
        res.pattern_overflow = pat_ovf;
        return 1'b1;
    endfunction

    function automatic item_t beat(input logic m, input logic [7:0] s, input logic l);
        item_t b;
        b.mode   = m;
        b.symbol = s;
        b.last   = l;
        return b;
    endfunction

    function automatic result_t rpt(input logic hit, input int unsigned start, input logic fin);
        result_t r;
        r.match_valid      = hit;
        r.match_start      = 16'(start);
        r.text_end         = fin;
        r.pattern_overflow = 1'b0;
        return r;
    endfunction

    function automatic logic [7:0] pick_sym(input logic [7:0] set [3], input bit noisy);
        if (noisy || $urandom_range(11) == 0)
            return 8'($urandom_range(255));
        return set[$urandom_range(2)];
    endfunction

    task automatic add_row(input item_t it, input row_chk_t chk = CHK_MODEL,
                           input result_t pin = '0);
        dir_row_t r;
        r.it  = it;
        r.chk = chk;
        r.pin = pin;
        dir_tab.insert(dir_tab.size(), r);
    endtask

    // Offers one beat, waits for it to be taken, then records what it should produce.
    task automatic offer_beat(input item_t it, input row_chk_t chk = CHK_MODEL,
                              input result_t pin = '0);
        result_t res;
        bit      got;
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        beats_in++;
        got = kmp_step(it, res);
        case (chk)
            CHK_MODEL:  if (got) pending_reports.insert(pending_reports.size(), res);
            CHK_REPORT: pending_reports.insert(pending_reports.size(), pin);
            default:    ;
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk)
        result_stall <= hold_off || (!calm && $urandom_range(99) < IDLE_PCT);

    // Long output hold-off, so the block backs up and stalls its input.
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            reports_seen++;
            if (result.match_valid)
                hits_seen++;
            if (result.pattern_overflow)
                ovf_seen++;
            if (pending_reports.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, got %h", $time, result);
                errors++;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("match_valid", want.match_valid, result.match_valid);
                check_field("match_start", want.match_start, result.match_start);
                check_field("text_end", want.text_end, result.text_end);
                check_field("pattern_overflow", want.pattern_overflow,
                            result.pattern_overflow);
            end
        end
    end

    initial
    begin
        logic [7:0] alpha [3];
        int         rand_goal;
        int         done;
        int         plen;
        int         tlen;
        int         shape;

        pat_len     = 0;
        border_len  = 0;
        scan_len    = 0;
        scan_pos    = 0;
        pat_ovf     = 1'b0;
        pat_open    = 1'b0;
        link_mem[0] = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Nothing loaded yet: only the text end reports.
        add_row(beat(MODE_TEXT, 8'h00, 1'b0), CHK_SILENT);
        add_row(beat(MODE_TEXT, 8'hFF, 1'b1), CHK_REPORT, rpt(1'b0, 0, 1'b1));
        // Symbol extremes, overlapping matches.
        add_row(beat(MODE_PATTERN, 8'h00, 1'b0));
        add_row(beat(MODE_PATTERN, 8'hFF, 1'b0));
        add_row(beat(MODE_PATTERN, 8'h00, 1'b1));
        add_row(beat(MODE_TEXT, 8'h00, 1'b0), CHK_SILENT);
        add_row(beat(MODE_TEXT, 8'hFF, 1'b0), CHK_SILENT);
        add_row(beat(MODE_TEXT, 8'h00, 1'b0), CHK_REPORT, rpt(1'b1, 0, 1'b0));
        add_row(beat(MODE_TEXT, 8'hFF, 1'b0), CHK_SILENT);
        add_row(beat(MODE_TEXT, 8'h00, 1'b1), CHK_REPORT, rpt(1'b1, 2, 1'b1));
        // Text cuts a pattern short; the stored byte is the pattern.
        add_row(beat(MODE_PATTERN, 8'h41, 1'b0));
        add_row(beat(MODE_TEXT, 8'h41, 1'b1), CHK_REPORT, rpt(1'b1, 0, 1'b1));
        // A closed pattern followed by another pattern byte starts over.
        add_row(beat(MODE_PATTERN, 8'h80, 1'b1));
        add_row(beat(MODE_PATTERN, 8'h7F, 1'b1));
        add_row(beat(MODE_TEXT, 8'h80, 1'b0), CHK_SILENT);
        add_row(beat(MODE_TEXT, 8'h7F, 1'b1), CHK_REPORT, rpt(1'b1, 1, 1'b1));
        // Mismatch after a partial match falls back through the failure link.
        add_row(beat(MODE_PATTERN, 8'h61, 1'b0));
        add_row(beat(MODE_PATTERN, 8'h61, 1'b0));
        add_row(beat(MODE_PATTERN, 8'h62, 1'b1));
        add_row(beat(MODE_TEXT, 8'h61, 1'b0));
        add_row(beat(MODE_TEXT, 8'h61, 1'b0));
        add_row(beat(MODE_TEXT, 8'h61, 1'b0));
        add_row(beat(MODE_TEXT, 8'h62, 1'b1), CHK_REPORT, rpt(1'b1, 1, 1'b1));
        foreach (dir_tab[i])
            offer_beat(dir_tab[i].it, dir_tab[i].chk, dir_tab[i].pin);

        // Every text byte matches while the output is held off.
        offer_beat(beat(MODE_PATTERN, 8'h61, 1'b1));
        hold_go = 1'b1;
        for (int j = 0; j < 40; j++)
            offer_beat(beat(MODE_TEXT, 8'h61, j == 39));

        // Pattern longer than the store; the extra bytes are dropped and flagged.
        for (int i = 0; i < PAT_MAX + 2; i++)
            offer_beat(beat(MODE_PATTERN, i < PAT_MAX ? 8'h3C : 8'($urandom_range(255)),
                            i == PAT_MAX + 1));
        for (int j = 0; j < 70; j++)
            offer_beat(beat(MODE_TEXT, 8'h3C, j == 69));

        // Random sequences: mostly a short pattern then a text run from a small
        // alphabet, with open runs, cut-short patterns and pure noise mixed in.
        rand_goal = beats_in + RANDOM_BEATS;
        while (beats_in < rand_goal)
        begin
            done = RANDOM_BEATS - (rand_goal - beats_in);
            calm <= (done > 300 && done < 550);
            shape = $urandom_range(9);
            for (int a = 0; a < 3; a++)
                alpha[a] = 8'($urandom_range(255));
            plen = (shape == 0) ? $urandom_range(PAT_MAX - 4, PAT_MAX + 6)
                                : $urandom_range(1, 6);
            tlen = $urandom_range(1, 40);
            for (int i = 0; i < plen; i++)
                offer_beat(beat(MODE_PATTERN, pick_sym(alpha, shape == 3),
                                i == plen - 1 && shape != 1));
            for (int j = 0; j < tlen; j++)
                offer_beat(beat(MODE_TEXT, pick_sym(alpha, shape == 3),
                                j == tlen - 1 && shape != 2));
        end
        item_valid <= 1'b0;
        calm       <= 1'b0;

        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d beats: directed rows, output hold-off, overflow, random runs.",
                 beats_in);
        $display("Checked %0d result beats, %0d with a match, %0d flagging overflow.",
                 reports_seen, hits_seen, ovf_seen);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: files.f
src/kmp_pkg.sv
src/kmp_string_matcher.sv
tb/testbench.sv
